// ----- hdl/lwc_pkg.sv -----
package lwc_pkg;

  localparam int CACHE_LINES  = 16;
  localparam int MEMORY_DEPTH = 1024;

  localparam int SLOT_W = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int CNT_W  = $clog2(CACHE_LINES + 1);
  localparam int ADDR_W = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;

  localparam int KIND_W     = 2;
  localparam int LADDR_W    = 10;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 5;
  localparam int WORDS_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;
  localparam logic [WORDS_W-1:0] WORDS_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LIST  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DATA = 2'd0,
    STATUS_LIST = 2'd1,
    STATUS_ERR  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 1'b0,
    CFG_MEM_WORDS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [LADDR_W-1:0]        address;
    logic signed [DATA_W-1:0]  write_value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [LADDR_W-1:0]        line_address;
    logic signed [DATA_W-1:0]  data;
    logic                      last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } store_req_t;

  typedef enum logic [2:0] {
    LOP_NONE    = 3'd0,
    LOP_EVICT_RD = 3'd1,
    LOP_EVICT   = 3'd2,
    LOP_HIT_RD  = 3'd3,
    LOP_HIT_WR  = 3'd4,
    LOP_INSTALL = 3'd5,
    LOP_LIST_RD = 3'd6
  } line_op_e;

  typedef struct packed {
    line_op_e           op;
    logic [LADDR_W-1:0] addr;
    logic [DATA_W-1:0]  value;
    logic [SLOT_W-1:0]  pos;
  } line_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [CNT_W-1:0]   resident;
    logic [LADDR_W-1:0] rd_tag;
    logic [DATA_W-1:0]  rd_value;
  } line_sts_t;

  typedef struct packed {
    logic [LADDR_W-1:0] tag;
    logic [DATA_W-1:0]  value;
  } line_t;

  typedef enum logic [3:0] {
    ST_INIT    = 4'd0,
    ST_IDLE    = 4'd1,
    ST_TRIM    = 4'd2,
    ST_WBACK   = 4'd3,
    ST_LOOKUP  = 4'd4,
    ST_HIT_OUT = 4'd5,
    ST_FETCH   = 4'd6,
    ST_INSTALL = 4'd7,
    ST_LIST    = 4'd8,
    ST_DRAIN   = 4'd9
  } state_e;

endpackage

// ----- hdl/lwc_store.sv -----
module lwc_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lwc_pkg::store_req_t        req_i,
  output logic [lwc_pkg::DATA_W-1:0] rdata_o,
  output logic                       ready_o
);
  import lwc_pkg::*;

  logic [DATA_W-1:0] mem_q [MEMORY_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_busy_q, clr_busy_d;

  // clearing sweep after reset, one word per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(MEMORY_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_busy_q;

endmodule

// ----- hdl/lwc_lines.sv -----
module lwc_lines (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lwc_pkg::line_cmd_t cmd_i,
  output lwc_pkg::line_sts_t sts_o
);
  import lwc_pkg::*;

  line_t              mem_q [CACHE_LINES];
  line_t              rd_q;
  logic [LADDR_W-1:0] tag_q [CACHE_LINES];
  logic [SLOT_W-1:0]  rank_q [CACHE_LINES];
  logic [SLOT_W-1:0]  rank_d [CACHE_LINES];
  logic [CACHE_LINES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]   resident_q, resident_d;

  logic [CACHE_LINES-1:0] hit_oh, lru_oh, list_oh, free_oh;
  logic [SLOT_W-1:0]  lru_rank, hit_rank, sel_slot;
  logic               mem_we, mem_re;

  function automatic logic [SLOT_W-1:0] oh_enc(input logic [CACHE_LINES-1:0] oh);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CACHE_LINES; i++) begin
      if (oh[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  // rank 0 is most recent; ranks of resident lines form 0 .. resident-1
  always_comb begin
    lru_rank = SLOT_W'(resident_q - CNT_W'(1));
    hit_rank = '0;
    for (int s = 0; s < CACHE_LINES; s++) begin
      hit_oh[s]  = valid_q[s] && (tag_q[s] == cmd_i.addr);
      lru_oh[s]  = valid_q[s] && (rank_q[s] == lru_rank);
      list_oh[s] = valid_q[s] && (rank_q[s] == cmd_i.pos);
      if (hit_oh[s]) hit_rank = hit_rank | rank_q[s];
    end
    // lowest free slot
    free_oh = ~valid_q & (valid_q + CACHE_LINES'(1));
  end

  always_comb begin
    sel_slot = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    valid_d  = valid_q;
    resident_d = resident_q;
    for (int s = 0; s < CACHE_LINES; s++) begin
      rank_d[s] = rank_q[s];
    end
    unique case (cmd_i.op) inside
      LOP_EVICT_RD: begin
        sel_slot = oh_enc(lru_oh);
        mem_re   = 1'b1;
      end
      LOP_EVICT: begin
        valid_d    = valid_q & ~lru_oh;
        resident_d = resident_q - CNT_W'(1);
      end
      LOP_HIT_RD, LOP_HIT_WR: begin
        sel_slot = oh_enc(hit_oh);
        mem_re   = (cmd_i.op == LOP_HIT_RD);
        mem_we   = (cmd_i.op == LOP_HIT_WR);
        for (int s = 0; s < CACHE_LINES; s++) begin
          if (hit_oh[s]) begin
            rank_d[s] = '0;
          end else if (valid_q[s] && (rank_q[s] < hit_rank)) begin
            rank_d[s] = rank_q[s] + SLOT_W'(1);
          end
        end
      end
      LOP_INSTALL: begin
        sel_slot = oh_enc(free_oh);
        mem_we   = 1'b1;
        valid_d  = valid_q | free_oh;
        resident_d = resident_q + CNT_W'(1);
        for (int s = 0; s < CACHE_LINES; s++) begin
          if (free_oh[s]) begin
            rank_d[s] = '0;
          end else if (valid_q[s]) begin
            rank_d[s] = rank_q[s] + SLOT_W'(1);
          end
        end
      end
      LOP_LIST_RD: begin
        sel_slot = oh_enc(list_oh);
        mem_re   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      resident_q <= '0;
      for (int s = 0; s < CACHE_LINES; s++) begin
        rank_q[s] <= '0;
      end
    end else begin
      valid_q    <= valid_d;
      resident_q <= resident_d;
      for (int s = 0; s < CACHE_LINES; s++) begin
        rank_q[s] <= rank_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < CACHE_LINES; s++) begin
      if ((cmd_i.op == LOP_INSTALL) && free_oh[s]) begin
        tag_q[s] <= cmd_i.addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[sel_slot] <= '{tag: cmd_i.addr, value: cmd_i.value};
    end
    if (mem_re) begin
      rd_q <= mem_q[sel_slot];
    end
  end

  assign sts_o = '{hit: |hit_oh, resident: resident_q, rd_tag: rd_q.tag, rd_value: rd_q.value};

endmodule

// ----- hdl/lwc_ctrl.sv -----
module lwc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  lwc_pkg::req_t               req_i,
  output logic                        res_valid_o,
  output lwc_pkg::res_t               res_o,
  input  logic [lwc_pkg::CNT_W-1:0]   cap_i,
  input  logic [lwc_pkg::WORDS_W-1:0] words_i,
  input  logic                        store_ready_i,
  input  logic [lwc_pkg::DATA_W-1:0]  store_rdata_i,
  output lwc_pkg::store_req_t         store_req_o,
  input  lwc_pkg::line_sts_t          line_sts_i,
  output lwc_pkg::line_cmd_t          line_cmd_o
);
  import lwc_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;
  logic              alloc_q, alloc_d;
  logic [SLOT_W-1:0] pos_q, pos_d;
  logic              lst_v_q, lst_v_d;
  logic              lst_last_q, lst_last_d;
  logic              is_read, oob, list_end;
  logic [DATA_W-1:0] fill_value;

  assign is_read  = (req_q.kind == KIND_READ);
  assign oob      = (32'(req_i.address) >= 32'(words_i))
                 || (32'(req_i.address) >= 32'(MEMORY_DEPTH));
  assign list_end = ((CNT_W'(pos_q) + CNT_W'(1)) == line_sts_i.resident);
  assign fill_value = is_read ? store_rdata_i : req_q.write_value;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    alloc_d     = alloc_q;
    pos_d       = pos_q;
    lst_v_d     = 1'b0;
    lst_last_d  = lst_last_q;

    store_req_o.we    = 1'b0;
    store_req_o.re    = 1'b0;
    store_req_o.addr  = ADDR_W'(req_q.address);
    store_req_o.wdata = req_q.write_value;

    line_cmd_o.op    = LOP_NONE;
    line_cmd_o.addr  = req_q.address;
    line_cmd_o.value = req_q.write_value;
    line_cmd_o.pos   = pos_q;

    // listing data arrives in the cycle after the line read
    if (lst_v_q) begin
      res_valid_d        = 1'b1;
      res_d.status       = STATUS_LIST;
      res_d.line_address = line_sts_i.rd_tag;
      res_d.data         = line_sts_i.rd_value;
      res_d.last         = lst_last_q;
    end

    unique case (state_q)
      ST_INIT: begin
        if (store_ready_i) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          case (req_i.kind) inside
            KIND_READ, KIND_WRITE: begin
              if (oob) begin
                res_valid_d        = 1'b1;
                res_d.status       = STATUS_ERR;
                res_d.line_address = req_i.address;
                res_d.data         = '0;
                res_d.last         = 1'b1;
              end else begin
                alloc_d = 1'b0;
                state_d = ST_TRIM;
              end
            end
            KIND_LIST: begin
              pos_d = '0;
              if (line_sts_i.resident != '0) state_d = ST_LIST;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TRIM: begin
        if (alloc_q || (line_sts_i.resident > cap_i)) begin
          line_cmd_o.op = LOP_EVICT_RD;
          state_d       = ST_WBACK;
        end else begin
          state_d = ST_LOOKUP;
        end
      end
      ST_WBACK: begin
        line_cmd_o.op     = LOP_EVICT;
        store_req_o.we    = 1'b1;
        store_req_o.addr  = ADDR_W'(line_sts_i.rd_tag);
        store_req_o.wdata = line_sts_i.rd_value;
        if (alloc_q) begin
          alloc_d = 1'b0;
          state_d = is_read ? ST_FETCH : ST_INSTALL;
        end else begin
          state_d = ST_TRIM;
        end
      end
      ST_LOOKUP: begin
        if (line_sts_i.hit) begin
          if (is_read) begin
            line_cmd_o.op = LOP_HIT_RD;
            state_d       = ST_HIT_OUT;
          end else begin
            line_cmd_o.op = LOP_HIT_WR;
            state_d       = ST_IDLE;
          end
        end else if (cap_i == '0) begin
          // no lines allowed: go straight to the store
          if (is_read) begin
            state_d = ST_FETCH;
          end else begin
            store_req_o.we = 1'b1;
            state_d        = ST_IDLE;
          end
        end else if (line_sts_i.resident >= cap_i) begin
          alloc_d = 1'b1;
          state_d = ST_TRIM;
        end else begin
          state_d = is_read ? ST_FETCH : ST_INSTALL;
        end
      end
      ST_FETCH: begin
        store_req_o.re = 1'b1;
        state_d        = ST_INSTALL;
      end
      ST_INSTALL: begin
        if (cap_i != '0) begin
          line_cmd_o.op    = LOP_INSTALL;
          line_cmd_o.value = fill_value;
        end
        if (is_read) begin
          res_valid_d        = 1'b1;
          res_d.status       = STATUS_DATA;
          res_d.line_address = req_q.address;
          res_d.data         = store_rdata_i;
          res_d.last         = 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_HIT_OUT: begin
        res_valid_d        = 1'b1;
        res_d.status       = STATUS_DATA;
        res_d.line_address = req_q.address;
        res_d.data         = line_sts_i.rd_value;
        res_d.last         = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_LIST: begin
        line_cmd_o.op = LOP_LIST_RD;
        lst_v_d       = 1'b1;
        lst_last_d    = list_end;
        pos_d         = pos_q + SLOT_W'(1);
        if (list_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      res_valid_q <= 1'b0;
      alloc_q     <= 1'b0;
      pos_q       <= '0;
      lst_v_q     <= 1'b0;
      lst_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      alloc_q     <= alloc_d;
      pos_q       <= pos_d;
      lst_v_q     <= lst_v_d;
      lst_last_q  <= lst_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/lru_writeback_cache.sv -----
// Fully associative LRU cache, write-allocate and write-back, in front of a
// MEMORY_DEPTH-word store. After reset the store is swept to zero, one word
// per cycle, and busy stays high until the sweep is done; config writes are
// taken at any time. A request is taken when start is high and busy is low.
// Results come out one per cycle with res_valid_o and must be taken in that
// cycle. The FSM walks the line memory and the store, each a synchronous RAM
// with registered read: a read hit passes TRIM, LOOKUP and HIT_OUT, a read
// miss TRIM, LOOKUP, FETCH and INSTALL, a write TRIM, LOOKUP and, on a miss
// with nonzero capacity, INSTALL; each line evicted on the way adds a line
// read, then a store write. An out-of-range address answers the next cycle.
// A listing of N resident lines gives N back-to-back registered results.
module lru_writeback_cache (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  lwc_pkg::req_t                  req_i,
  output logic                           res_valid_o,
  output lwc_pkg::res_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lwc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lwc_pkg::*;

  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [WORDS_W-1:0] words_q, words_d;
  logic [CNT_W-1:0]   cap_eff;
  store_req_t         store_req;
  logic [DATA_W-1:0]  store_rdata;
  logic               store_ready;
  line_cmd_t          line_cmd;
  line_sts_t          line_sts;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cap_d   = cap_q;
    words_d = words_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CAPACITY:  cap_d   = cfg_data_i[CAP_W-1:0];
        CFG_MEM_WORDS: words_d = cfg_data_i[WORDS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      words_q <= WORDS_RESET;
    end else begin
      cap_q   <= cap_d;
      words_q <= words_d;
    end
  end

  assign cap_eff = (32'(cap_q) > 32'(CACHE_LINES)) ? CNT_W'(CACHE_LINES) : CNT_W'(cap_q);

  lwc_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata),
    .ready_o (store_ready)
  );

  lwc_lines u_lines (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (line_cmd),
    .sts_o  (line_sts)
  );

  lwc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o),
    .cap_i         (cap_eff),
    .words_i       (words_q),
    .store_ready_i (store_ready),
    .store_rdata_i (store_rdata),
    .store_req_o   (store_req),
    .line_sts_i    (line_sts),
    .line_cmd_o    (line_cmd)
  );

endmodule

// ----- hdl/lwc_checker.sv -----
module lwc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input lwc_pkg::req_t req_i,
  input logic          res_valid_o,
  input lwc_pkg::res_t res_o
);
  import lwc_pkg::*;

  // an error result is always a lone, zero-data result
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == STATUS_ERR) |-> res_o.last && (res_o.data == '0))
    else $error("error result with data or without last");

  // read data is always the only result of its request
  a_data_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == STATUS_DATA) |-> res_o.last)
    else $error("read data without last");

  // a listing streams without gaps until last
  a_list_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && (res_o.status == STATUS_LIST))
    else $error("listing stream broken");

  // an unknown request kind does nothing
  a_unknown_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !((req_i.kind == KIND_READ) || (req_i.kind == KIND_WRITE)
      || (req_i.kind == KIND_LIST)) |=> !res_valid_o && !busy)
    else $error("unknown request kind caused activity");

endmodule

bind lru_writeback_cache lwc_checker u_lwc_checker (.*);
